// ===== hw/rtl/d2pc_pkg.sv =====
package d2pc_pkg;

  // position counters
  localparam int CNT_W     = 12;
  localparam int CNT_LIMIT = 4096;

  // queue depths
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [15:0] depth_raw;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        frame_start;
  } pixel_t;

  typedef struct packed {
    logic signed [39:0] point_x;
    logic signed [39:0] point_y;
    logic [31:0]        point_z;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
  } point_t;

  // placed pixel handed from front to back
  typedef struct packed {
    logic [15:0]      depth_raw;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } work_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [23:0] inv_depth_scale;
    logic [31:0] depth_lo;
    logic [31:0] depth_hi;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_CENTER_X        = 3'd1,
    REG_CENTER_Y        = 3'd2,
    REG_INV_FOCAL_X     = 3'd3,
    REG_INV_FOCAL_Y     = 3'd4,
    REG_INV_DEPTH_SCALE = 3'd5,
    REG_DEPTH_LO        = 3'd6,
    REG_DEPTH_HI        = 3'd7
  } reg_idx_t;

  localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [15:0] RST_CENTER_X        = 16'd5112;
  localparam logic [15:0] RST_CENTER_Y        = 16'd3832;
  localparam logic [23:0] RST_INV_FOCAL_X     = 24'd31957;
  localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd31957;
  localparam logic [23:0] RST_INV_DEPTH_SCALE = 24'd16777;
  localparam logic [31:0] RST_DEPTH_LO        = 32'd0;
  localparam logic [31:0] RST_DEPTH_HI        = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/depth_to_point_cloud.sv =====
// depth image to point cloud back-projection
// input channel: push/full carry one raster-order pixel (raw depth, blue,
//   green, red, frame_start); a transfer happens when push is high and full
//   is low. frame_start places the pixel at row 0, column 0.
// result channel: empty/pop; the oldest point sits on point while empty is
//   low and leaves on a cycle with pop high. zero or one point per pixel:
//   zero depth or z outside the lower/upper depth registers gives none.
// config: apb-style port, register i at byte address 4*i, pready always high;
//   write only while no pixel is in flight.
// path: kept pixel -> work queue -> back-end stages 1 to 4 -> result queue.
// throughput: one pixel per cycle sustained while pop keeps the result queue
//   drained; the four-stage multiply chain in the back end is fully pipelined,
//   credits against the result queue keep it from overrunning.
// stalls: if pop stays low the result queue fills, the back end stops taking
//   work and the 4-entry work queue then raises full.
// reset: rst clears counters, queues and registers to their defaults.
module depth_to_point_cloud #(
  parameter int MAX_IMAGE_WIDTH  = 4096,
  parameter int MAX_IMAGE_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // pixel input
  input  logic              push,
  input  d2pc_pkg::pixel_t  pixel,
  output logic              full,
  // point output
  output logic              empty,
  input  logic              pop,
  output d2pc_pkg::point_t  point,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  d2pc_pkg::cfg_t   cfg;
  d2pc_pkg::reg_idx_t reg_idx;
  logic             cfg_wr;
  logic             accept;

  d2pc_pkg::work_t  work_in;
  d2pc_pkg::work_t  work_head;
  logic             work_push;
  logic             mid_empty;
  logic             mid_pop;

  d2pc_pkg::point_t point_in;
  logic             out_push;
  logic [d2pc_pkg::OUT_CNT_W-1:0] out_count;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = d2pc_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= d2pc_pkg::RST_IMAGE_WIDTH;
      cfg.center_x        <= d2pc_pkg::RST_CENTER_X;
      cfg.center_y        <= d2pc_pkg::RST_CENTER_Y;
      cfg.inv_focal_x     <= d2pc_pkg::RST_INV_FOCAL_X;
      cfg.inv_focal_y     <= d2pc_pkg::RST_INV_FOCAL_Y;
      cfg.inv_depth_scale <= d2pc_pkg::RST_INV_DEPTH_SCALE;
      cfg.depth_lo        <= d2pc_pkg::RST_DEPTH_LO;
      cfg.depth_hi        <= d2pc_pkg::RST_DEPTH_HI;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        d2pc_pkg::REG_IMAGE_WIDTH:     cfg.image_width     <= pwdata[12:0];
        d2pc_pkg::REG_CENTER_X:        cfg.center_x        <= pwdata[15:0];
        d2pc_pkg::REG_CENTER_Y:        cfg.center_y        <= pwdata[15:0];
        d2pc_pkg::REG_INV_FOCAL_X:     cfg.inv_focal_x     <= pwdata[23:0];
        d2pc_pkg::REG_INV_FOCAL_Y:     cfg.inv_focal_y     <= pwdata[23:0];
        d2pc_pkg::REG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= pwdata[23:0];
        d2pc_pkg::REG_DEPTH_LO:        cfg.depth_lo        <= pwdata;
        d2pc_pkg::REG_DEPTH_HI:        cfg.depth_hi        <= pwdata;
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    unique case (reg_idx)
      d2pc_pkg::REG_IMAGE_WIDTH:     prdata = 32'(cfg.image_width);
      d2pc_pkg::REG_CENTER_X:        prdata = 32'(cfg.center_x);
      d2pc_pkg::REG_CENTER_Y:        prdata = 32'(cfg.center_y);
      d2pc_pkg::REG_INV_FOCAL_X:     prdata = 32'(cfg.inv_focal_x);
      d2pc_pkg::REG_INV_FOCAL_Y:     prdata = 32'(cfg.inv_focal_y);
      d2pc_pkg::REG_INV_DEPTH_SCALE: prdata = 32'(cfg.inv_depth_scale);
      d2pc_pkg::REG_DEPTH_LO:        prdata = cfg.depth_lo;
      d2pc_pkg::REG_DEPTH_HI:        prdata = cfg.depth_hi;
    endcase
  end

  // input transfer
  assign accept = push && !full;

  // front: position tracking, zero-depth drop
  d2pc_front #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .image_width (cfg.image_width),
    .work_push   (work_push),
    .work        (work_in)
  );

  // work queue between front and back; its full is the input full
  d2pc_fifo #(
    .WIDTH ($bits(d2pc_pkg::work_t)),
    .DEPTH (d2pc_pkg::MID_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (work_push),
    .wdata (work_in),
    .full  (full),
    .pop   (mid_pop),
    .rdata (work_head),
    .empty (mid_empty),
    .count ()
  );

  // back: z, range check, projection, saturation
  d2pc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (work_head),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_point (point_in)
  );

  // result queue feeding the output channel
  d2pc_fifo #(
    .WIDTH ($bits(d2pc_pkg::point_t)),
    .DEPTH (d2pc_pkg::OUT_DEPTH)
  ) u_point_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (point_in),
    .full  (),
    .pop   (pop),
    .rdata (point),
    .empty (empty),
    .count (out_count)
  );

endmodule

// ===== hw/rtl/d2pc_fifo.sv =====
module d2pc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/d2pc_front.sv =====
module d2pc_front #(
  parameter int MAX_IMAGE_WIDTH  = 4096,
  parameter int MAX_IMAGE_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  d2pc_pkg::pixel_t  pixel,
  input  logic [12:0]       image_width,
  output logic              work_push,
  output d2pc_pkg::work_t   work
);

  localparam int CW    = d2pc_pkg::CNT_W;
  localparam int W_LIM = (MAX_IMAGE_WIDTH < d2pc_pkg::CNT_LIMIT) ?
                         MAX_IMAGE_WIDTH : d2pc_pkg::CNT_LIMIT;
  localparam int H_LIM = (MAX_IMAGE_HEIGHT < d2pc_pkg::CNT_LIMIT) ?
                         MAX_IMAGE_HEIGHT : d2pc_pkg::CNT_LIMIT;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [CW:0]   width_eff;
  logic [CW:0]   col_inc;
  logic [CW:0]   row_inc;
  logic          col_wrap;
  logic          row_wrap;

  always_comb begin
    col = pixel.frame_start ? '0 : column_count;
    row = pixel.frame_start ? '0 : row_count;
    priority if (image_width == '0) begin
      width_eff = (CW+1)'(1);
    end else if ((CW+1)'(image_width) > (CW+1)'(W_LIM)) begin
      width_eff = (CW+1)'(W_LIM);
    end else begin
      width_eff = (CW+1)'(image_width);
    end
    col_inc  = {1'b0, col} + 1'b1;
    row_inc  = {1'b0, row} + 1'b1;
    col_wrap = (col_inc >= width_eff);
    row_wrap = (row_inc >= (CW+1)'(H_LIM));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_inc[CW-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
        row_count    <= row;
      end
    end
  end

  // no measurement: dropped here, position still advances
  assign work_push      = accept && (pixel.depth_raw != '0);
  assign work.depth_raw = pixel.depth_raw;
  assign work.blue      = pixel.blue;
  assign work.green     = pixel.green;
  assign work.red       = pixel.red;
  assign work.col       = col;
  assign work.row       = row;

endmodule

// ===== hw/rtl/d2pc_back.sv =====
module d2pc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  d2pc_pkg::cfg_t                   cfg,
  input  d2pc_pkg::work_t                  head,
  input  logic                             mid_empty,
  output logic                             mid_pop,
  input  logic [d2pc_pkg::OUT_CNT_W-1:0]   out_count,
  output logic                             out_push,
  output d2pc_pkg::point_t                 out_point
);

  localparam int OW = d2pc_pkg::OUT_CNT_W + 1;

  function automatic logic [39:0] sat_coord(input logic [44:0] r, input logic neg);
    logic [39:0] v;
    if (neg) begin
      if (r >= 45'h80_0000_0000) begin
        v = 40'h80_0000_0000;
      end else begin
        v = ~r[39:0] + 1'b1;
      end
    end else begin
      if (r > 45'h7F_FFFF_FFFF) begin
        v = 40'h7F_FFFF_FFFF;
      end else begin
        v = r[39:0];
      end
    end
    return v;
  endfunction

  // stage 1: depth product, center offsets
  logic        v1;
  logic [39:0] prod1;
  logic [15:0] magx1, magy1;
  logic        negx1, negy1;
  logic [7:0]  red1, green1, blue1;
  // stage 2: z and range check
  logic        v2;
  logic [31:0] z2;
  logic [15:0] magx2, magy2;
  logic        negx2, negy2;
  logic [7:0]  red2, green2, blue2;
  // stage 3: offset times z
  logic        v3;
  logic [31:0] z3;
  logic [47:0] tx3, ty3;
  logic        negx3, negy3;
  logic [7:0]  red3, green3, blue3;
  // stage 4: split reciprocal products
  logic        v4;
  logic [31:0] z4;
  logic [59:0] ax4, bx4, ay4, by4;
  logic        negx4, negy4;
  logic [7:0]  red4, green4, blue4;

  logic signed [16:0] dx, dy;
  logic [15:0]        magx, magy;
  logic [39:0]        zsum;
  logic [31:0]        z1;
  logic               in_range;
  logic [60:0]        sumx, sumy;
  logic [2:0]         inflight;

  assign inflight = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);
  // credit: every item in the pipe has a slot waiting in the result queue
  assign mid_pop  = !mid_empty &&
                    ((OW'(out_count) + OW'(inflight)) < OW'(d2pc_pkg::OUT_DEPTH));

  always_comb begin
    dx   = $signed({1'b0, head.col, 4'b0000}) - $signed({1'b0, cfg.center_x});
    dy   = $signed({1'b0, head.row, 4'b0000}) - $signed({1'b0, cfg.center_y});
    magx = dx[16] ? 16'(-dx) : dx[15:0];
    magy = dy[16] ? 16'(-dy) : dy[15:0];
    zsum = prod1 + 40'd128;
    z1   = zsum[39:8];
    in_range = (z1 >= cfg.depth_lo) && (z1 <= cfg.depth_hi);
    sumx = 61'(ax4) + 61'(bx4 >> 12) + 61'(32768);
    sumy = 61'(ay4) + 61'(by4 >> 12) + 61'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= mid_pop;
      v2 <= v1 && in_range;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod1  <= 40'(head.depth_raw) * 40'(cfg.inv_depth_scale);
    magx1  <= magx;
    magy1  <= magy;
    negx1  <= dx[16];
    negy1  <= dy[16];
    red1   <= head.red;
    green1 <= head.green;
    blue1  <= head.blue;

    z2     <= z1;
    magx2  <= magx1;
    magy2  <= magy1;
    negx2  <= negx1;
    negy2  <= negy1;
    red2   <= red1;
    green2 <= green1;
    blue2  <= blue1;

    z3     <= z2;
    tx3    <= 48'(magx2) * 48'(z2);
    ty3    <= 48'(magy2) * 48'(z2);
    negx3  <= negx2;
    negy3  <= negy2;
    red3   <= red2;
    green3 <= green2;
    blue3  <= blue2;

    z4     <= z3;
    ax4    <= 60'(tx3) * 60'(cfg.inv_focal_x[23:12]);
    bx4    <= 60'(tx3) * 60'(cfg.inv_focal_x[11:0]);
    ay4    <= 60'(ty3) * 60'(cfg.inv_focal_y[23:12]);
    by4    <= 60'(ty3) * 60'(cfg.inv_focal_y[11:0]);
    negx4  <= negx3;
    negy4  <= negy3;
    red4   <= red3;
    green4 <= green3;
    blue4  <= blue3;
  end

  assign out_push              = v4;
  assign out_point.point_x     = sat_coord(sumx[60:16], negx4);
  assign out_point.point_y     = sat_coord(sumy[60:16], negy4);
  assign out_point.point_z     = z4;
  assign out_point.point_red   = red4;
  assign out_point.point_green = green4;
  assign out_point.point_blue  = blue4;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_count != d2pc_pkg::OUT_CNT_W'(d2pc_pkg::OUT_DEPTH)))
    else $error("result queue written while full");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("work queue read while empty");
  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("stage 2 valid without stage 1");
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (OW'(out_count) + OW'(inflight)) <= OW'(d2pc_pkg::OUT_DEPTH))
    else $error("pipeline holds more items than result slots");
`endif

endmodule
